// ===== rtl/core/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
`default_nettype none
package cdq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned OUTC_W = 2;
	localparam int unsigned FILL_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_DONE      = 2'd0,
		OUTC_OVERFLOW  = 2'd1,
		OUTC_UNDERFLOW = 2'd2
	} outc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic exec;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic pop_ok;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/cdq_datapath.sv =====
// Deque datapath: ring indices, fill count, ring storage and result registers.
`default_nettype none
module cdq_datapath #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cdq_pkg::cmd_t               cmd,
	output      cdq_pkg::sts_t               sts,
	input  wire logic [cdq_pkg::OP_W-1:0]    op,
	input  wire logic [cdq_pkg::WORD_W-1:0]  push_word,
	output      logic [cdq_pkg::WORD_W-1:0]  popped_word,
	output      logic [cdq_pkg::OUTC_W-1:0]  outcome,
	output      logic [cdq_pkg::FILL_W-1:0]  fill_level
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cdq_pkg::op_t   op_e;
	cdq_pkg::outc_t outcome_q;

	logic [AW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;
	logic [cdq_pkg::WORD_W-1:0] popped_q;
	logic [cdq_pkg::WORD_W-1:0] rdata;

	logic [AW-1:0] front_prev, front_next, back_prev, back_next;
	logic          is_push, full, empty;
	logic          push_ok, pop_ok;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW+cdq_pkg::FILL_W-1:0] count_ext;

	assign op_e = cdq_pkg::op_t'(op);

	assign front_prev = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_next = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - AW'(1);
	assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + AW'(1);

	assign is_push = (op_e == cdq_pkg::OP_PUSH_FRONT) || (op_e == cdq_pkg::OP_PUSH_BACK);
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign push_ok = is_push && !full;
	assign pop_ok  = !is_push && !empty;

	assign sts.pop_ok = pop_ok;

	assign wr_en   = cmd.exec && push_ok;
	assign wr_addr = (op_e == cdq_pkg::OP_PUSH_FRONT) ? front_prev : back_q;
	assign rd_en   = cmd.exec && pop_ok;
	assign rd_addr = (op_e == cdq_pkg::OP_POP_FRONT) ? front_q : back_prev;

	cdq_ram #(
		.WIDTH(cdq_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(push_word),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			back_q    <= '0;
			count_q   <= '0;
			outcome_q <= cdq_pkg::OUTC_DONE;
		end else if (cmd.exec) begin
			case (op_e)
				cdq_pkg::OP_PUSH_FRONT: begin
					if (push_ok) begin
						front_q <= front_prev;
						count_q <= count_q + CW'(1);
					end
				end
				cdq_pkg::OP_PUSH_BACK: begin
					if (push_ok) begin
						back_q  <= back_next;
						count_q <= count_q + CW'(1);
					end
				end
				cdq_pkg::OP_POP_FRONT: begin
					if (pop_ok) begin
						front_q <= front_next;
						count_q <= count_q - CW'(1);
					end
				end
				cdq_pkg::OP_POP_BACK: begin
					if (pop_ok) begin
						back_q  <= back_prev;
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
			if (is_push) begin
				outcome_q <= full ? cdq_pkg::OUTC_OVERFLOW : cdq_pkg::OUTC_DONE;
			end else begin
				outcome_q <= empty ? cdq_pkg::OUTC_UNDERFLOW : cdq_pkg::OUTC_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_q <= '0;
		end else if (cmd.capture) begin
			popped_q <= rdata;
		end
	end

	assign count_ext   = {{cdq_pkg::FILL_W{1'b0}}, count_q};
	assign fill_level  = count_ext[cdq_pkg::FILL_W-1:0];
	assign popped_word = popped_q;
	assign outcome     = outcome_q;

endmodule
`default_nettype wire

// ===== rtl/core/cdq_ctrl.sv =====
// Deque controller: accept one beat, wait on a ring read when needed, present the result.
`default_nettype none
module cdq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	output      cdq_pkg::cmd_t cmd,
	input  wire cdq_pkg::sts_t sts
);

	cdq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		cmd.exec    = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			cdq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = sts.pop_ok ? cdq_pkg::ST_READ : cdq_pkg::ST_OUT;
				end
			end
			cdq_pkg::ST_READ: begin
				cmd.capture = 1'b1;
				state_d     = cdq_pkg::ST_OUT;
			end
			cdq_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = cdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/circular_deque.sv =====
// Top level of the circular deque.
// Double-ended queue of DEPTH signed 32-bit words kept in a ring RAM. Each input
// beat carries an operation in s_tuser (push front, push back, pop front, pop
// back) and the word to push in s_tdata; each gives exactly one result beat with
// the popped word (zero on pushes and refused pops), an outcome in m_tuser (done,
// overflow, underflow) and the fill level after the operation. One operation is
// in flight at a time: a push or a refused operation shows its result in the cycle
// after acceptance, while a successful pop first passes through ST_READ, where the
// registered read data of the ring RAM is captured; a new beat is taken only after
// the result beat has left.
// The ring RAM needs no clearing after reset; only written entries are ever read.
`default_nettype none
module circular_deque #(
	parameter int unsigned DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] push_word
	input  wire logic [1:0]  s_tuser,   // [1:0] op
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [39:0] m_tdata,   // [31:0] popped_word, [35:32] fill_level, zero fill
	output      logic [1:0]  m_tuser    // [1:0] outcome
);

	cdq_pkg::cmd_t cmd;
	cdq_pkg::sts_t sts;

	logic [cdq_pkg::WORD_W-1:0] popped_word;
	logic [cdq_pkg::FILL_W-1:0] fill_level;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	cdq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (s_tuser),
		.push_word  (s_tdata),
		.popped_word(popped_word),
		.outcome    (m_tuser),
		.fill_level (fill_level)
	);

	assign m_tdata = {4'b0000, fill_level, popped_word};

endmodule
`default_nettype wire

// ===== rtl/core/cdq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
`default_nettype none
module cdq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	logic unused_in;
	assign unused_in = ^{s_tdata, s_tuser, m_tdata[31:0]};

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_no_input_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second input beat taken before its result");

	a_drop_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (!m_tvalid && s_tready))
		else $error("result repeated or input not reopened");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped before acceptance");

	a_fields_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != 2'd3 && m_tdata[39:36] == 4'd0))
		else $error("illegal outcome code or nonzero pad");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
`default_nettype wire
